// File: rtl/core/ufbs_pkg.sv
// Shared types and constants of the disjoint-set engine.
// No dependencies; imported by every module of the block.
package ufbs_pkg;

   localparam int ELEM_W               = 10;
   localparam int SIZE_W               = 11;
   localparam int MAX_ELEMENTS_DEFAULT = 1024;

   localparam logic [SIZE_W-1:0] COUNT_RESET = 11'd1024;

   localparam logic CMD_QUERY = 1'b0;
   localparam logic CMD_UNION = 1'b1;

   // read and write strobes of one memory
   typedef struct packed {
      logic re;
      logic we;
   } mem_ctl_type;

endpackage

// File: rtl/core/ufbs_ram.sv
// Synchronous single-read, single-write memory with a registered read port.
// Depends on ufbs_pkg for the strobe struct.
module ufbs_ram #(
   parameter int DEPTH = ufbs_pkg::MAX_ELEMENTS_DEFAULT,
   parameter int WIDTH = ufbs_pkg::SIZE_W,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  ufbs_pkg::mem_ctl_type ctl,
   input  logic [AW-1:0]         raddr,
   input  logic [AW-1:0]         waddr,
   input  logic [WIDTH-1:0]      wdata,
   output logic [WIDTH-1:0]      rdata
);
   import ufbs_pkg::*;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // write-first: a read of the entry being written returns the new data
   always_ff @(posedge clock) begin
      if (ctl.re) begin
         if (ctl.we && (waddr == raddr)) begin
            rdata_ff <= wdata;
         end else begin
            rdata_ff <= mem_ff[raddr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/core/ufbs_ctrl.sv
// Sequencer of the disjoint-set engine: clearing pass, two-pass find with
// path compression, union by size and the result register.
// Depends on ufbs_pkg; drives the parent and size memories.
module ufbs_ctrl #(
   parameter int MAX_ELEMENTS = ufbs_pkg::MAX_ELEMENTS_DEFAULT,
   localparam int IDX_W       = $clog2(MAX_ELEMENTS),
   localparam int SZ_W        = $clog2(MAX_ELEMENTS + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   // request side
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_cmd,
   input  logic [IDX_W-1:0]      req_a,
   input  logic [IDX_W-1:0]      req_b,
   input  logic                  req_err,
   // result side
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [IDX_W-1:0]      rsp_root,
   output logic [SZ_W-1:0]       rsp_size,
   output logic                  rsp_merged,
   output logic                  rsp_err,
   // parent link memory
   output ufbs_pkg::mem_ctl_type p_ctl,
   output logic [IDX_W-1:0]      p_raddr,
   output logic [IDX_W-1:0]      p_waddr,
   output logic [IDX_W-1:0]      p_wdata,
   input  logic [IDX_W-1:0]      p_rdata,
   // set size memory
   output ufbs_pkg::mem_ctl_type s_ctl,
   output logic [IDX_W-1:0]      s_raddr,
   output logic [IDX_W-1:0]      s_waddr,
   output logic [SZ_W-1:0]       s_wdata,
   input  logic [SZ_W-1:0]       s_rdata
);
   import ufbs_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FIND_UP,
      ST_FIND_FIX,
      ST_LINK,
      ST_RESULT
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic [IDX_W-1:0] node_ff, node_in;
   logic [IDX_W-1:0] start_ff, start_in;
   logic [IDX_W-1:0] top_ff, top_in;
   logic [IDX_W-1:0] elem_b_ff, elem_b_in;
   logic             cmd_ff, cmd_in;
   logic             second_ff, second_in;
   logic [IDX_W-1:0] ra_ff, ra_in;
   logic [SZ_W-1:0]  size_a_ff, size_a_in;
   logic [IDX_W-1:0] res_root_ff, res_root_in;
   logic [SZ_W-1:0]  res_size_ff, res_size_in;
   logic             res_merged_ff, res_merged_in;
   logic             res_err_ff, res_err_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0] rsp_root_ff, rsp_root_in;
   logic [SZ_W-1:0]  rsp_size_ff, rsp_size_in;
   logic             rsp_merged_ff, rsp_merged_in;
   logic             rsp_err_ff, rsp_err_in;

   logic             out_free;
   logic [SZ_W-1:0]  size_sum;

   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // disjoint sets, so the sum never exceeds the element count
   assign size_sum  = size_a_ff + s_rdata;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      node_in       = node_ff;
      start_in      = start_ff;
      top_in        = top_ff;
      elem_b_in     = elem_b_ff;
      cmd_in        = cmd_ff;
      second_in     = second_ff;
      ra_in         = ra_ff;
      size_a_in     = size_a_ff;
      res_root_in   = res_root_ff;
      res_size_in   = res_size_ff;
      res_merged_in = res_merged_ff;
      res_err_in    = res_err_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_root_in   = rsp_root_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_merged_in = rsp_merged_ff;
      rsp_err_in    = rsp_err_ff;

      p_ctl   = '0;
      p_raddr = node_ff;
      p_waddr = node_ff;
      p_wdata = top_ff;
      s_ctl   = '0;
      s_raddr = node_ff;
      s_waddr = top_ff;
      s_wdata = size_sum;

      case (state_ff)
         ST_CLEAR: begin
            p_ctl.we = 1'b1;
            p_waddr  = clr_ff;
            p_wdata  = clr_ff;
            s_ctl.we = 1'b1;
            s_waddr  = clr_ff;
            s_wdata  = SZ_W'(1);
            if (clr_ff == IDX_W'(MAX_ELEMENTS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_cmd;
               elem_b_in = req_b;
               if (req_err) begin
                  res_root_in   = '0;
                  res_size_in   = '0;
                  res_merged_in = 1'b0;
                  res_err_in    = 1'b1;
                  state_in      = ST_RESULT;
               end else begin
                  node_in   = req_a;
                  start_in  = req_a;
                  second_in = 1'b0;
                  p_ctl.re  = 1'b1;
                  p_raddr   = req_a;
                  state_in  = ST_FIND_UP;
               end
            end
         end
         ST_FIND_UP: begin
            // p_rdata is the parent of node_ff
            if (p_rdata == node_ff) begin
               top_in   = node_ff;
               s_ctl.re = 1'b1;
               s_raddr  = node_ff;
               p_ctl.re = 1'b1;
               p_raddr  = start_ff;
               node_in  = start_ff;
               state_in = ST_FIND_FIX;
            end else begin
               p_ctl.re = 1'b1;
               p_raddr  = p_rdata;
               node_in  = p_rdata;
            end
         end
         ST_FIND_FIX: begin
            if (node_ff != top_ff) begin
               // point this node at the root, move on to its old parent
               p_ctl.we = 1'b1;
               p_waddr  = node_ff;
               p_wdata  = top_ff;
               p_ctl.re = 1'b1;
               p_raddr  = p_rdata;
               node_in  = p_rdata;
            end else if (!second_ff) begin
               ra_in     = top_ff;
               size_a_in = s_rdata;
               if (cmd_ff == CMD_UNION) begin
                  second_in = 1'b1;
                  node_in   = elem_b_ff;
                  start_in  = elem_b_ff;
                  p_ctl.re  = 1'b1;
                  p_raddr   = elem_b_ff;
                  state_in  = ST_FIND_UP;
               end else begin
                  res_root_in   = top_ff;
                  res_size_in   = s_rdata;
                  res_merged_in = 1'b0;
                  res_err_in    = 1'b0;
                  state_in      = ST_RESULT;
               end
            end else begin
               state_in = ST_LINK;
            end
         end
         ST_LINK: begin
            // top_ff is the root of b, s_rdata its size
            res_err_in = 1'b0;
            if (ra_ff == top_ff) begin
               res_root_in   = ra_ff;
               res_size_in   = size_a_ff;
               res_merged_in = 1'b0;
            end else if (size_a_ff < s_rdata) begin
               p_ctl.we      = 1'b1;
               p_waddr       = ra_ff;
               p_wdata       = top_ff;
               s_ctl.we      = 1'b1;
               s_waddr       = top_ff;
               res_root_in   = top_ff;
               res_size_in   = size_sum;
               res_merged_in = 1'b1;
            end else begin
               p_ctl.we      = 1'b1;
               p_waddr       = top_ff;
               p_wdata       = ra_ff;
               s_ctl.we      = 1'b1;
               s_waddr       = ra_ff;
               res_root_in   = ra_ff;
               res_size_in   = size_sum;
               res_merged_in = 1'b1;
            end
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_root_in   = res_root_ff;
               rsp_size_in   = res_size_ff;
               rsp_merged_in = res_merged_ff;
               rsp_err_in    = res_err_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      node_ff       <= node_in;
      start_ff      <= start_in;
      top_ff        <= top_in;
      elem_b_ff     <= elem_b_in;
      cmd_ff        <= cmd_in;
      second_ff     <= second_in;
      ra_ff         <= ra_in;
      size_a_ff     <= size_a_in;
      res_root_ff   <= res_root_in;
      res_size_ff   <= res_size_in;
      res_merged_ff <= res_merged_in;
      res_err_ff    <= res_err_in;
      rsp_root_ff   <= rsp_root_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_merged_ff <= rsp_merged_in;
      rsp_err_ff    <= rsp_err_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_root   = rsp_root_ff;
   assign rsp_size   = rsp_size_ff;
   assign rsp_merged = rsp_merged_ff;
   assign rsp_err    = rsp_err_ff;

   a_result_from_result_state: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESULT))
      else $error("result loaded outside the result state");

   a_error_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_err_ff |-> rsp_root_ff == '0 && rsp_size_ff == '0 && !rsp_merged_ff)
      else $error("error result carries non-zero fields");

   a_good_result_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_err_ff |-> rsp_size_ff != '0)
      else $error("set of size zero reported");

   a_compress_not_root: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIND_FIX && p_ctl.we |-> p_waddr != top_ff)
      else $error("path compression wrote the root's own link");

   a_link_no_self: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LINK && p_ctl.we |-> p_waddr != p_wdata && s_ctl.we)
      else $error("union linked a root to itself or without a size update");

endmodule

// File: rtl/core/union_find_by_size_top.sv
// Top level of the disjoint-set engine: count register, index checks and the
// sequencer with its parent link and set size memories.
// Depends on ufbs_pkg, ufbs_ram and ufbs_ctrl.
//
// Disjoint-set engine, union by size with path compression, over MAX_ELEMENTS
// elements. After reset a clearing pass makes every element a singleton; no
// request is taken during it, the count register can be written. One request
// is worked on at a time. A query finds the root of elem_a and then points the
// path at it; a union does so for elem_a and then elem_b and links the two
// roots. A request with a bad index goes straight to its result. The parent
// link memory has a single read port that follows one link per cycle, once to
// find the root and once to point the path at it. The next request is taken
// while the previous result still waits at the output register.
module union_find_by_size_top #(
   parameter int MAX_ELEMENTS = ufbs_pkg::MAX_ELEMENTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // configuration
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ufbs_pkg::SIZE_W-1:0]   csr_element_count,
   // requests
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_command,
   input  logic [ufbs_pkg::ELEM_W-1:0]   req_elem_a,
   input  logic [ufbs_pkg::ELEM_W-1:0]   req_elem_b,
   // results
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ufbs_pkg::ELEM_W-1:0]   rsp_root,
   output logic [ufbs_pkg::SIZE_W-1:0]   rsp_set_size,
   output logic                          rsp_merged,
   output logic                          rsp_index_error
);
   import ufbs_pkg::*;

   localparam int IDX_W = $clog2(MAX_ELEMENTS);
   localparam int SZ_W  = $clog2(MAX_ELEMENTS + 1);
   localparam int IW    = (ELEM_W > IDX_W) ? ELEM_W : IDX_W;
   localparam int CW    = (SIZE_W > SZ_W) ? SIZE_W : SZ_W;

   logic [SIZE_W-1:0] count_ff;
   logic [CW-1:0]     count_wide;
   logic [CW-1:0]     count_max;
   logic [CW-1:0]     count_act;
   logic              a_bad;
   logic              b_bad;
   logic              req_err;
   logic [IW-1:0]     a_wide;
   logic [IW-1:0]     b_wide;
   logic [IW-1:0]     root_wide;
   logic [CW-1:0]     size_wide;

   logic [IDX_W-1:0]  c_root;
   logic [SZ_W-1:0]   c_size;

   mem_ctl_type       p_ctl;
   logic [IDX_W-1:0]  p_raddr;
   logic [IDX_W-1:0]  p_waddr;
   logic [IDX_W-1:0]  p_wdata;
   logic [IDX_W-1:0]  p_rdata;
   mem_ctl_type       s_ctl;
   logic [IDX_W-1:0]  s_raddr;
   logic [IDX_W-1:0]  s_waddr;
   logic [SZ_W-1:0]   s_wdata;
   logic [SZ_W-1:0]   s_rdata;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
      end else if (csr_valid) begin
         count_ff <= csr_element_count;
      end
   end

   // count in use is the register clamped to the memory depth
   assign count_wide = CW'(count_ff);
   assign count_max  = CW'(MAX_ELEMENTS);
   assign count_act  = (count_wide > count_max) ? count_max : count_wide;
   assign a_bad      = (CW'(req_elem_a) >= count_act);
   assign b_bad      = (CW'(req_elem_b) >= count_act);
   assign req_err    = a_bad || ((req_command == CMD_UNION) && b_bad);

   assign a_wide = IW'(req_elem_a);
   assign b_wide = IW'(req_elem_b);

   ufbs_ctrl #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_cmd    (req_command),
      .req_a      (a_wide[IDX_W-1:0]),
      .req_b      (b_wide[IDX_W-1:0]),
      .req_err    (req_err),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_root   (c_root),
      .rsp_size   (c_size),
      .rsp_merged (rsp_merged),
      .rsp_err    (rsp_index_error),
      .p_ctl      (p_ctl),
      .p_raddr    (p_raddr),
      .p_waddr    (p_waddr),
      .p_wdata    (p_wdata),
      .p_rdata    (p_rdata),
      .s_ctl      (s_ctl),
      .s_raddr    (s_raddr),
      .s_waddr    (s_waddr),
      .s_wdata    (s_wdata),
      .s_rdata    (s_rdata)
   );

   ufbs_ram #(
      .DEPTH (MAX_ELEMENTS),
      .WIDTH (IDX_W)
   ) u_parent_ram (
      .clock (clock),
      .ctl   (p_ctl),
      .raddr (p_raddr),
      .waddr (p_waddr),
      .wdata (p_wdata),
      .rdata (p_rdata)
   );

   ufbs_ram #(
      .DEPTH (MAX_ELEMENTS),
      .WIDTH (SZ_W)
   ) u_size_ram (
      .clock (clock),
      .ctl   (s_ctl),
      .raddr (s_raddr),
      .waddr (s_waddr),
      .wdata (s_wdata),
      .rdata (s_rdata)
   );

   assign root_wide    = IW'(c_root);
   assign size_wide    = CW'(c_size);
   assign rsp_root     = root_wide[ELEM_W-1:0];
   assign rsp_set_size = size_wide[SIZE_W-1:0];

endmodule
